// ===== rtl/greedy_rectangle_merge_core_defines.svh =====
// Assertion macros used by the checker file of the rectangle merge core.
`ifndef GREEDY_RECTANGLE_MERGE_CORE_DEFINES_SVH
`define GREEDY_RECTANGLE_MERGE_CORE_DEFINES_SVH

// Check at every clock edge outside reset.
`define GRM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check at every clock edge, reset included.
`define GRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/grm_pkg.sv =====
// Shared types, constants and command/status structs of the rectangle merge core.
`default_nettype none

package grm_pkg;

    localparam int GRID_W_DEF  = 8;
    localparam int GRID_H_DEF  = 8;
    localparam int MAX_RESULTS = 64;

    localparam int BLOCK_W = 8;
    localparam int X0_W    = 3;
    localparam int X1_W    = 4;
    localparam int TEX_W   = 8;

    localparam logic [BLOCK_W-1:0] ID_OFFSET = 8'd2;

    localparam int S_TDATA_W = 16;
    localparam int RECT_BITS = 2 * X0_W + 2 * X1_W + TEX_W;
    localparam int M_TDATA_W = 24;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_MERGE_MODE = 1'b0;
    localparam logic MODE_RENDER    = 1'b0;
    localparam logic MODE_PHYSICS   = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START_RD,
        ST_START_CHK,
        ST_Y_RD,
        ST_Y_CHK,
        ST_MARK,
        ST_X_RD,
        ST_X_CHK,
        ST_PUSH,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic load_final;
        logic rd_start;
        logic rd_y;
        logic rd_x;
        logic start_take;
        logic y_inc;
        logic mark;
        logic x_inc;
        logic skip;
        logic push;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic start_end;
        logic y_end;
        logic x_end;
        logic span_end;
        logic col_last;
        logic push_end;
        logic out_free;
        logic pend_valid;
    } stat_t;

    typedef struct packed {
        logic [TEX_W-1:0] tex;
        logic [X1_W-1:0]  y1;
        logic [X1_W-1:0]  x1;
        logic [X0_W-1:0]  y0;
        logic [X0_W-1:0]  x0;
    } rect_t;

endpackage

`default_nettype wire

// ===== rtl/grm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module grm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/grm_ctrl.sv =====
// Sweep controller: load, start search, run growth, column extension, result push, final flush.
`default_nettype none

module grm_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tlast,
    output logic                s_tready,
    input  wire grm_pkg::stat_t stat,
    output grm_pkg::cmd_t       cmd
);

    import grm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_wr = 1'b1;
                    if (s_tlast) begin
                        cmd.load_final = 1'b1;
                        state_next     = ST_START_RD;
                    end
                end
            end
            ST_START_RD: begin
                cmd.rd_start = 1'b1;
                state_next   = ST_START_CHK;
            end
            ST_START_CHK: begin
                if (stat.hit) begin
                    cmd.start_take = 1'b1;
                    state_next     = stat.start_end ? ST_MARK : ST_Y_RD;
                end else begin
                    cmd.skip   = 1'b1;
                    state_next = (stat.start_end && stat.col_last) ? ST_FLUSH : ST_START_RD;
                end
            end
            ST_Y_RD: begin
                cmd.rd_y   = 1'b1;
                state_next = ST_Y_CHK;
            end
            ST_Y_CHK: begin
                if (stat.hit) begin
                    cmd.y_inc  = 1'b1;
                    state_next = stat.y_end ? ST_MARK : ST_Y_RD;
                end else begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                cmd.mark   = 1'b1;
                state_next = stat.x_end ? ST_PUSH : ST_X_RD;
            end
            ST_X_RD: begin
                cmd.rd_x   = 1'b1;
                state_next = ST_X_CHK;
            end
            ST_X_CHK: begin
                if (!stat.hit) begin
                    state_next = ST_PUSH;
                end else if (stat.span_end) begin
                    state_next = ST_MARK;
                end else begin
                    cmd.x_inc  = 1'b1;
                    state_next = ST_X_RD;
                end
            end
            ST_PUSH: begin
                // hold until the older pending word can move to the output
                if (!stat.pend_valid || stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = (stat.push_end && stat.col_last) ? ST_FLUSH : ST_START_RD;
                end
            end
            ST_FLUSH: begin
                if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/grm_dp.sv =====
// Datapath: cell store, used map, sweep counters, pending and output result registers.
`default_nettype none

module grm_dp #(
    parameter int GRID_W = grm_pkg::GRID_W_DEF,
    parameter int GRID_H = grm_pkg::GRID_H_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire grm_pkg::cmd_t               cmd,
    output grm_pkg::stat_t                   stat,
    input  wire logic                        merge_mode,
    input  wire logic [grm_pkg::BLOCK_W-1:0] cell_block,
    input  wire logic                        cell_solid,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic [grm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);

    import grm_pkg::*;

    localparam int CELLS  = GRID_W * GRID_H;
    localparam int AW     = $clog2(CELLS);
    localparam int BX_W   = $clog2(GRID_W);
    localparam int EX_W   = $clog2(GRID_W + 1);
    localparam int BY_W   = $clog2(GRID_H);
    localparam int EY_W   = $clog2(GRID_H + 1);
    localparam int N_W    = $clog2(MAX_RESULTS + 1);
    localparam int CELL_W = BLOCK_W + 1;

    logic [AW-1:0]      load_idx_reg, load_idx_next;
    logic [CELLS-1:0]   used_reg, used_next;
    logic [CELLS-1:0]   mark_vec;
    logic [BX_W-1:0]    bx_reg, bx_next;
    logic [BY_W-1:0]    by_reg, by_next;
    logic [EY_W-1:0]    ey_reg, ey_next;
    logic [EX_W-1:0]    ex_reg, ex_next;
    logic [BY_W-1:0]    y_reg, y_next;
    logic [BLOCK_W-1:0] sid_reg, sid_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [AW-1:0]      addr_reg;
    logic               start_chk_reg;
    logic               pend_valid_reg, pend_valid_next;
    rect_t              pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    rect_t              out_reg, out_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_last_reg, out_last_next;

    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;
    logic [BLOCK_W-1:0] rd_id;
    logic               rd_solid;
    logic [BLOCK_W-1:0] cmp_id;
    logic               usable;
    rect_t              new_rect;

    function automatic logic [AW-1:0] cell_addr(input logic [EX_W-1:0] x,
                                                input logic [BY_W-1:0] y);
        return AW'(x) * AW'(GRID_H) + AW'(y);
    endfunction

    assign ram_re = cmd.rd_start | cmd.rd_y | cmd.rd_x;

    always_comb begin
        if (cmd.rd_x) begin
            ram_raddr = cell_addr(ex_reg, y_reg);
        end else if (cmd.rd_y) begin
            ram_raddr = cell_addr(EX_W'(bx_reg), BY_W'(ey_reg));
        end else begin
            ram_raddr = cell_addr(EX_W'(bx_reg), by_reg);
        end
    end

    grm_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (cmd.load_wr),
        .waddr (load_idx_reg),
        .wdata ({cell_solid, cell_block}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[BLOCK_W-1:0];
    assign rd_solid = ram_rdata[BLOCK_W];
    assign cmp_id   = start_chk_reg ? rd_id : sid_reg;

    always_comb begin
        if (merge_mode == MODE_PHYSICS) begin
            usable = rd_solid;
        end else begin
            usable = (cmp_id >= ID_OFFSET) && (rd_id == cmp_id);
        end
    end

    for (genvar g = 0; g < CELLS; g++) begin : g_mark
        localparam int COL = g / GRID_H;
        localparam int ROW = g % GRID_H;
        assign mark_vec[g] = (ex_reg == EX_W'(COL)) &&
                             (EY_W'(ROW) >= EY_W'(by_reg)) &&
                             (EY_W'(ROW) < ey_reg);
    end

    always_comb begin
        new_rect.x0  = X0_W'(bx_reg);
        new_rect.y0  = X0_W'(by_reg);
        new_rect.x1  = X1_W'(ex_reg);
        new_rect.y1  = X1_W'(ey_reg);
        new_rect.tex = (merge_mode == MODE_PHYSICS) ? '0 : sid_reg - ID_OFFSET;
    end

    always_comb begin
        stat.hit        = !used_reg[addr_reg] && usable;
        stat.start_end  = (by_reg == BY_W'(GRID_H - 1));
        stat.y_end      = (ey_reg == EY_W'(GRID_H - 1));
        stat.x_end      = (ex_reg == EX_W'(GRID_W - 1));
        stat.span_end   = ((EY_W'(y_reg) + 1'b1) == ey_reg);
        stat.col_last   = (bx_reg == BX_W'(GRID_W - 1));
        stat.push_end   = (ey_reg == EY_W'(GRID_H));
        stat.out_free   = !out_valid_reg || m_tready;
        stat.pend_valid = pend_valid_reg;
    end

    always_comb begin
        load_idx_next   = load_idx_reg;
        used_next       = used_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        ey_next         = ey_reg;
        ex_next         = ex_reg;
        y_next          = y_reg;
        sid_next        = sid_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cmd.load_wr) begin
            load_idx_next = (load_idx_reg == AW'(CELLS - 1)) ? '0 : load_idx_reg + 1'b1;
        end
        if (cmd.load_final) begin
            load_idx_next = '0;
            used_next     = '0;
            bx_next       = '0;
            by_next       = '0;
            n_next        = '0;
        end

        if (cmd.start_take) begin
            sid_next = rd_id;
            ey_next  = EY_W'(by_reg) + 1'b1;
            ex_next  = EX_W'(bx_reg);
        end
        if (cmd.y_inc) begin
            ey_next = ey_reg + 1'b1;
        end
        if (cmd.mark) begin
            used_next = used_reg | mark_vec;
            ex_next   = ex_reg + 1'b1;
            y_next    = by_reg;
        end
        if (cmd.x_inc) begin
            y_next = y_reg + 1'b1;
        end

        if (cmd.skip) begin
            if (by_reg == BY_W'(GRID_H - 1)) begin
                by_next = '0;
                bx_next = bx_reg + 1'b1;
            end else begin
                by_next = by_reg + 1'b1;
            end
        end

        if (cmd.push) begin
            if (ey_reg == EY_W'(GRID_H)) begin
                by_next = '0;
                bx_next = bx_reg + 1'b1;
            end else begin
                by_next = BY_W'(ey_reg);
            end
            // drop rectangles beyond the result cap
            if (n_reg < N_W'(MAX_RESULTS)) begin
                n_next          = n_reg + 1'b1;
                pend_next       = new_rect;
                pend_valid_next = 1'b1;
                if (pend_valid_reg) begin
                    out_next       = pend_reg;
                    out_empty_next = 1'b0;
                    out_last_next  = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
        end

        if (cmd.flush) begin
            out_valid_next  = 1'b1;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_empty_next = 1'b0;
            end else begin
                out_next       = '0;
                out_empty_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_idx_reg   <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            load_idx_reg   <= load_idx_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        ey_reg        <= ey_next;
        ex_reg        <= ex_next;
        y_reg         <= y_next;
        sid_reg       <= sid_next;
        n_reg         <= n_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
        if (ram_re) begin
            addr_reg      <= ram_raddr;
            start_chk_reg <= cmd.rd_start;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/greedy_rectangle_merge_core.sv =====
// Top level of the greedy rectangle merge core: APB register, controller and datapath.
// Loading: s_tready is high in the load state; the sweep starts the cycle after the final cell word.
// Sweep: each cell test is a read state then a check state (cell store registered read); each
// marked column adds a mark state, each rectangle a push state; push and flush can stall on the output.
// The first result reaches the output register when the second rectangle is pushed or at sweep end.
// Reset clears the controller, load index, used map and valid flags; the cell store is not cleared.
`default_nettype none

module greedy_rectangle_merge_core #(
    parameter int GRID_W = grm_pkg::GRID_W_DEF,
    parameter int GRID_H = grm_pkg::GRID_H_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: cell_block [7:0], cell_solid [8], zero pad; s_tlast: cell_final
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [grm_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                         s_tlast,
    // m_tdata: rect_x0 [2:0], rect_y0 [5:3], rect_x1 [9:6], rect_y1 [13:10],
    //          tex_index [21:14], zero pad; m_tuser: grid_empty; m_tlast: rect_last
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [grm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [grm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [grm_pkg::APB_DW-1:0]   pwdata,
    output logic [grm_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    import grm_pkg::*;

    logic  merge_mode_reg;
    logic  merge_mode_next;
    logic  reg_sel;
    cmd_t  cmd;
    stat_t stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_MERGE_MODE);

    always_comb begin
        merge_mode_next = merge_mode_reg;
        if (psel && penable && pwrite && reg_sel) begin
            merge_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_mode_reg <= MODE_RENDER;
        end else begin
            merge_mode_reg <= merge_mode_next;
        end
    end

    assign prdata = reg_sel ? APB_DW'(merge_mode_reg) : '0;

    grm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    grm_dp #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .merge_mode (merge_mode_reg),
        .cell_block (s_tdata[BLOCK_W-1:0]),
        .cell_solid (s_tdata[BLOCK_W]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/grm_checker.sv =====
// Port-level checker of the rectangle merge core and its bind to the top level.
`default_nettype none
`include "greedy_rectangle_merge_core_defines.svh"

module grm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [grm_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          m_tlast
);

    import grm_pkg::*;

    `GRM_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result word changed")

    `GRM_ASSERT(a_empty_alone, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)), "empty word not last or not zero")

    `GRM_ASSERT(a_final_stops_load, aclk, aresetn, (s_tvalid && s_tready && s_tlast) |=> !s_tready, "input taken during sweep")

    `GRM_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind greedy_rectangle_merge_core grm_checker u_grm_checker (.*);

`default_nettype wire
